>>> design/css_pkg.sv
// Shared constants and types for the curvature statistics core.
package css_pkg;
   localparam int SampleBits = 16;
   localparam logic [16:0] MaxSamples = 17'd65536;
   localparam logic [62:0] ValMask = {63{1'b1}};

   localparam logic [2:0] MET_MEAN     = 3'd0;
   localparam logic [2:0] MET_MAX      = 3'd1;
   localparam logic [2:0] MET_MIN      = 3'd2;
   localparam logic [2:0] MET_VARIANCE = 3'd3;
   localparam logic [2:0] MET_STDDEV   = 3'd4;
   localparam logic [2:0] MET_TOTAL    = 3'd5;
   localparam logic [2:0] MET_ENERGY   = 3'd6;
   localparam logic [2:0] MET_RANGE    = 3'd7;

   // command to the shared unit
   typedef struct packed {
      logic         start;
      logic         is_sqrt;
      logic [127:0] num;
      logic [63:0]  den;
   } op_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] quo;
   } op_rsp_type;
endpackage

>>> design/css_divsqrt.sv
// Shared bit-serial unit: 128/64 restoring divide or 128-bit floor square root.
module css_divsqrt (
   input  logic                clock,
   input  logic                reset,
   input  css_pkg::op_req_type op_req,
   output css_pkg::op_rsp_type op_rsp
);
   logic         busy_ff, busy_in;
   logic         sq_ff, sq_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] x_ff, x_in;
   logic [64:0]  r_ff, r_in;
   logic [63:0]  d_ff, d_in;
   logic [127:0] q_ff, q_in;
   logic [65:0]  sr_ff, sr_in;
   logic         done_ff, done_in;
   logic [64:0]  rs;
   logic [65:0]  sr_shift;
   logic [65:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      sr_in   = sr_ff;
      done_in = 1'b0;
      rs       = {r_ff[63:0], x_ff[127]};
      sr_shift = {sr_ff[63:0], x_ff[127:126]};
      trial    = {q_ff[63:0], 2'b01};
      if (op_req.start) begin
         busy_in = 1'b1;
         sq_in   = op_req.is_sqrt;
         cnt_in  = 7'd0;
         x_in    = op_req.num;
         r_in    = '0;
         d_in    = op_req.den;
         q_in    = '0;
         sr_in   = '0;
      end else if (busy_ff) begin
         if (sq_ff) begin
            // one result bit from two radicand bits
            x_in = {x_ff[125:0], 2'b00};
            if (sr_shift >= trial) begin
               sr_in = sr_shift - trial;
               q_in  = {q_ff[126:0], 1'b1};
            end else begin
               sr_in = sr_shift;
               q_in  = {q_ff[126:0], 1'b0};
            end
            if (cnt_ff == 7'd63) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            x_in = {x_ff[126:0], 1'b0};
            if (rs >= {1'b0, d_ff}) begin
               r_in = rs - {1'b0, d_ff};
               q_in = {q_ff[126:0], 1'b1};
            end else begin
               r_in = rs;
               q_in = {q_ff[126:0], 1'b0};
            end
            if (cnt_ff == 7'd127) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sq_ff  <= sq_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      sr_ff  <= sr_in;
   end

   assign op_rsp.done = done_ff;
   assign op_rsp.quo  = q_ff;
endmodule

>>> design/css_mul.sv
// Registered 32x32 multiplier used for wide products in 32-bit pieces.
module css_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);
   logic [63:0] p_ff, p_in;
   assign p_in = {32'd0, mul_a} * {32'd0, mul_b};
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
   assign mul_p = p_ff;
endmodule

>>> design/curvature_stream_statistics_core.sv
// Top level: streaming curvature, unit tangent and curve summary metrics.
//
// Usage: samples enter on the req_ channel (tdata = sample, tlast = final
// sample). Each sample after the second, up to the 65536th, gives one
// per-point response on the rsp_ channel (tuser = 0); a sample with tlast
// set is followed by eight metric responses (tuser = 1), tlast marking the
// last response of a request. A request that completes a point runs two
// square roots and three divides in turn on one shared bit-serial unit,
// plus 32x32 multiplies and handoff. The summary adds two divides, one
// square root and six multiplies. req_tready is low while a request is
// worked on. Each response waits in an output register; a stall on
// rsp_tready holds the sequencer until the response is taken. Reset
// (synchronous, active high) clears the running statistics and the sample
// history.
module curvature_stream_statistics_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // sample[15:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_index[15:0], curvature[47:16], tangent_x[63:48], tangent_y[79:64],
   // metric_id[82:80], metric_value[145:83], zero fill
   output logic [151:0] rsp_tdata,
   output logic         rsp_tuser,  // kind
   output logic         rsp_tlast
);
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SQ1   = 5'd1;
   localparam logic [4:0] S_SQ1W  = 5'd2;
   localparam logic [4:0] S_DV1   = 5'd3;
   localparam logic [4:0] S_DV1W  = 5'd4;
   localparam logic [4:0] S_SQ2   = 5'd5;
   localparam logic [4:0] S_SQ2W  = 5'd6;
   localparam logic [4:0] S_DV2   = 5'd7;
   localparam logic [4:0] S_DV2W  = 5'd8;
   localparam logic [4:0] S_DV3   = 5'd9;
   localparam logic [4:0] S_DV3W  = 5'd10;
   localparam logic [4:0] S_KSQ   = 5'd11;
   localparam logic [4:0] S_KSQW  = 5'd12;
   localparam logic [4:0] S_PEMIT = 5'd13;
   localparam logic [4:0] S_FIN   = 5'd14;
   localparam logic [4:0] S_MUL   = 5'd15;
   localparam logic [4:0] S_MULW  = 5'd16;
   localparam logic [4:0] S_VDV   = 5'd17;
   localparam logic [4:0] S_VDVW  = 5'd18;
   localparam logic [4:0] S_MDV   = 5'd19;
   localparam logic [4:0] S_MDVW  = 5'd20;
   localparam logic [4:0] S_SSQ   = 5'd21;
   localparam logic [4:0] S_SSQW  = 5'd22;
   localparam logic [4:0] S_MEMIT = 5'd23;
   localparam logic [4:0] S_WAIT  = 5'd24;

   logic [4:0]   st_ff, st_in, ret_ff, ret_in;
   logic signed [15:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [16:0]  cnt_ff, cnt_in;
   logic [62:0]  tot_ff, tot_in, en_ff, en_in;
   logic [31:0]  mx_ff, mx_in, mn_ff, mn_in;
   logic         fin_ff, fin_in;
   logic [16:0]  adx_ff, adx_in;
   logic [17:0]  ad2_ff, ad2_in;
   logic         neg_ff, neg_in;
   logic [63:0]  m_ff, m_in, sq_ff, sq_in;
   logic [31:0]  kap_ff, kap_in;
   logic [15:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [15:0]  pidx_ff, pidx_in;
   logic [2:0]   step_ff, step_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] ne_ff, ne_in;
   logic [62:0]  var_ff, var_in, mean_ff, mean_in, sd_ff, sd_in;
   logic [2:0]   mid_ff, mid_in;
   logic         ov_ff, ov_in;
   logic [151:0] od_ff, od_in;
   logic         ou_ff, ou_in, ol_ff, ol_in;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   css_pkg::op_req_type op_req;
   css_pkg::op_rsp_type op_rsp;

   css_divsqrt u_unit (.clock(clock), .reset(reset), .op_req(op_req), .op_rsp(op_rsp));
   css_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

   logic signed [17:0] dx_w, d2_w;
   logic [33:0]  dxsq;
   logic [63:0]  dd;
   logic [16:0]  n_w;
   logic [63:0]  quo_lo;
   logic         quo_big;
   logic [63:0]  kap_sum;
   logic [63:0]  en_sum;
   logic [63:0]  esq;
   logic [31:0]  mmul_a, mmul_b;
   logic [127:0] diff;

   assign dxsq   = {17'd0, adx_ff} * {17'd0, adx_ff};
   assign dd     = {30'd0, dxsq} + 64'd4;
   assign n_w    = cnt_ff - 17'd2;
   assign quo_lo = op_rsp.quo[63:0];
   assign quo_big = (op_rsp.quo[127:63] != '0);

   // multiply schedule: steps 0..4 build n*E (n is 17 bits) and S*S in pieces, step 5 gives n*n
   always_comb begin
      mmul_a = '0;
      mmul_b = '0;
      case (step_ff)
         3'd0: begin mmul_a = {15'd0, n_w}; mmul_b = en_ff[31:0]; end
         3'd1: begin mmul_a = {15'd0, n_w}; mmul_b = {1'b0, en_ff[62:32]}; end
         3'd2: begin mmul_a = tot_ff[31:0]; mmul_b = tot_ff[31:0]; end
         3'd3: begin mmul_a = tot_ff[31:0]; mmul_b = {1'b0, tot_ff[62:32]}; end
         3'd4: begin mmul_a = {1'b0, tot_ff[62:32]}; mmul_b = {1'b0, tot_ff[62:32]}; end
         3'd5: begin mmul_a = {15'd0, n_w}; mmul_b = {15'd0, n_w}; end
         default: begin mmul_a = '0; mmul_b = '0; end
      endcase
   end

   always_comb begin
      st_in = st_ff; ret_in = ret_ff;
      p1_in = p1_ff; p2_in = p2_ff; cnt_in = cnt_ff;
      tot_in = tot_ff; en_in = en_ff; mx_in = mx_ff; mn_in = mn_ff;
      fin_in = fin_ff;
      adx_in = adx_ff; ad2_in = ad2_ff; neg_in = neg_ff;
      m_in = m_ff; sq_in = sq_ff; kap_in = kap_ff; tx_in = tx_ff; ty_in = ty_ff;
      pidx_in = pidx_ff; step_in = step_ff; acc_in = acc_ff; ne_in = ne_ff;
      var_in = var_ff; mean_in = mean_ff; sd_in = sd_ff; mid_in = mid_ff;
      ov_in = ov_ff; od_in = od_ff; ou_in = ou_ff; ol_in = ol_ff;
      op_req = '0;
      mul_a = '0; mul_b = '0;
      dx_w = '0; d2_w = '0;
      kap_sum = '0; en_sum = '0; esq = '0; diff = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               fin_in = req_tlast;
               if (cnt_ff < css_pkg::MaxSamples) begin
                  p2_in = p1_ff;
                  p1_in = $signed(req_tdata);
                  cnt_in = cnt_ff + 17'd1;
                  pidx_in = cnt_ff[15:0] - 16'd2;
                  dx_w = 18'($signed(req_tdata)) - 18'(p2_ff);
                  d2_w = 18'($signed(req_tdata)) - (18'(p1_ff) <<< 1) + 18'(p2_ff);
                  neg_in = dx_w[17];
                  adx_in = dx_w[17] ? 17'(-dx_w) : dx_w[16:0];
                  ad2_in = d2_w[17] ? 18'(-d2_w) : 18'(d2_w);
                  if (cnt_ff >= 17'd2) begin
                     st_in = S_SQ1;
                  end else st_in = req_tlast ? S_FIN : S_IDLE;
               end else st_in = req_tlast ? S_FIN : S_IDLE;
            end
         end
         S_SQ1: begin // m = isqrt((dx^2+1)<<28)
            op_req.start = 1'b1; op_req.is_sqrt = 1'b1;
            op_req.num = 128'({dd - 64'd3, 28'd0});
            st_in = S_SQ1W;
         end
         S_SQ1W: if (op_rsp.done) begin m_in = quo_lo; st_in = S_DV1; end
         S_DV1: begin
            op_req.start = 1'b1;
            op_req.num = 128'({adx_ff, 29'd0});
            op_req.den = m_ff;
            st_in = S_DV1W;
         end
         S_DV1W: if (op_rsp.done) begin
            if (neg_ff)
               tx_in = 16'(17'h10000 - ((quo_lo > 64'd32768) ? 17'd32768 : quo_lo[16:0]));
            else tx_in = (quo_lo > 64'd32767) ? 16'd32767 : quo_lo[15:0];
            st_in = S_DV2;
         end
         S_DV2: begin
            op_req.start = 1'b1;
            op_req.num = 128'h1 << 29;
            op_req.den = m_ff;
            st_in = S_DV2W;
         end
         S_DV2W: if (op_rsp.done) begin
            ty_in = (quo_lo > 64'd32768) ? 16'd32768 : quo_lo[15:0];
            st_in = S_SQ2;
         end
         S_SQ2: begin
            op_req.start = 1'b1; op_req.is_sqrt = 1'b1;
            op_req.num = 128'({dd, 28'd0});
            st_in = S_SQ2W;
         end
         S_SQ2W: if (op_rsp.done) begin sq_in = quo_lo; step_in = 3'd0; st_in = S_KSQ; end
         S_KSQ: begin // dd*sq in 32-bit pieces (dd < 2^35, sq < 2^32)
            mul_a = (step_ff == 3'd0) ? dd[31:0] : {29'd0, dd[34:32]};
            mul_b = sq_ff[31:0];
            st_in = S_KSQW;
         end
         S_KSQW: begin
            if (step_ff == 3'd0) begin
               acc_in = {64'd0, mul_p};
               step_in = 3'd1;
               st_in = S_KSQ;
            end else begin
               acc_in = acc_ff + {32'd0, mul_p, 32'd0};
               st_in = S_DV3;
            end
         end
         S_DV3: begin
            op_req.start = 1'b1;
            op_req.num = 128'({ad2_ff, 31'd0});
            op_req.den = acc_ff[63:0];
            st_in = S_DV3W;
         end
         S_DV3W: if (op_rsp.done) begin
            kap_in = (op_rsp.quo[127:32] != '0) ? 32'hFFFF_FFFF : quo_lo[31:0];
            step_in = 3'd0;
            st_in = S_MUL; ret_in = S_PEMIT;
         end
         S_MUL: begin // kap^2 for energy
            mul_a = kap_ff; mul_b = kap_ff;
            st_in = S_MULW;
         end
         S_MULW: begin
            esq = mul_p;
            kap_sum = {1'b0, tot_ff} + {32'd0, kap_ff};
            tot_in = kap_sum[63] ? css_pkg::ValMask : kap_sum[62:0];
            en_sum = {1'b0, en_ff} + {1'b0, (esq[63] ? css_pkg::ValMask : esq[62:0])};
            en_in = en_sum[63] ? css_pkg::ValMask : en_sum[62:0];
            if (kap_ff > mx_ff) mx_in = kap_ff;
            if (kap_ff < mn_ff) mn_in = kap_ff;
            st_in = ret_ff;
         end
         S_PEMIT: if (!ov_ff || rsp_tready) begin
            ov_in = 1'b1; ou_in = 1'b0; ol_in = !fin_ff;
            od_in = '0;
            od_in[15:0] = pidx_ff; od_in[47:16] = kap_ff;
            od_in[63:48] = tx_ff; od_in[79:64] = ty_ff;
            st_in = fin_ff ? S_FIN : S_WAIT;
         end
         S_FIN: begin
            step_in = 3'd0; ne_in = '0; acc_in = '0;
            if (cnt_ff >= 17'd3) st_in = S_VDV;
            else begin
               var_in = '0; mean_in = '0; sd_in = '0;
               tot_in = '0; en_in = '0; mx_in = '0; mn_in = '0;
               mid_in = css_pkg::MET_MEAN; st_in = S_MEMIT;
            end
         end
         S_VDV: begin // accumulate n*E and S^2, and form n^2, over steps 0..5
            mul_a = mmul_a; mul_b = mmul_b;
            st_in = S_VDVW;
         end
         S_VDVW: begin
            case (step_ff)
               3'd0: ne_in = {64'd0, mul_p};
               3'd1: ne_in = ne_ff + {32'd0, mul_p, 32'd0};
               3'd2: acc_in = {64'd0, mul_p};
               3'd3: acc_in = acc_ff + {31'd0, mul_p, 33'd0};
               3'd4: acc_in = acc_ff + {mul_p, 64'd0};
               default: m_in = mul_p;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               diff = ne_ff - acc_ff;
               ne_in = (ne_ff >= acc_ff) ? diff : '0;
               st_in = S_MDV;
            end else st_in = S_VDV;
         end
         S_MDV: begin
            op_req.start = 1'b1;
            op_req.num = ne_ff;
            op_req.den = m_ff;
            st_in = S_MDVW;
         end
         S_MDVW: if (op_rsp.done) begin
            var_in = quo_big ? css_pkg::ValMask : quo_lo[62:0];
            st_in = S_SSQ;
         end
         S_SSQ: begin
            op_req.start = 1'b1;
            op_req.num = {64'd0, 1'b0, tot_ff};
            op_req.den = {47'd0, n_w};
            st_in = S_SSQW;
         end
         S_SSQW: if (op_rsp.done) begin
            mean_in = quo_lo[62:0];
            step_in = 3'd6;
            st_in = S_MEMIT; mid_in = css_pkg::MET_MEAN;
            ret_in = S_MEMIT;
         end
         S_MEMIT: begin
            if (step_ff == 3'd6) begin // stddev square root, run once
               op_req.start = 1'b1; op_req.is_sqrt = 1'b1;
               op_req.num = {65'd0, var_ff};
               step_in = 3'd7;
            end else if (step_ff == 3'd7) begin
               if (op_rsp.done) begin sd_in = quo_lo[62:0]; step_in = 3'd0; end
            end else if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; ou_in = 1'b1;
               ol_in = (mid_ff == css_pkg::MET_RANGE);
               od_in = '0;
               od_in[82:80] = mid_ff;
               case (mid_ff)
                  css_pkg::MET_MEAN:     od_in[145:83] = mean_ff;
                  css_pkg::MET_MAX:      od_in[145:83] = {31'd0, mx_ff};
                  css_pkg::MET_MIN:      od_in[145:83] = {31'd0, mn_ff};
                  css_pkg::MET_VARIANCE: od_in[145:83] = var_ff;
                  css_pkg::MET_STDDEV:   od_in[145:83] = sd_ff;
                  css_pkg::MET_TOTAL:    od_in[145:83] = tot_ff;
                  css_pkg::MET_ENERGY:   od_in[145:83] = en_ff;
                  default:               od_in[145:83] = {31'd0, mx_ff - mn_ff};
               endcase
               mid_in = mid_ff + 3'd1;
               if (mid_ff == css_pkg::MET_RANGE) begin
                  st_in = S_WAIT;
                  p1_in = '0; p2_in = '0; cnt_in = '0; tot_in = '0; en_in = '0;
                  mx_in = '0; mn_in = '1;
               end
            end
         end
         S_WAIT: if (!ov_ff || rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ret_ff <= S_IDLE;
         p1_ff <= '0; p2_ff <= '0; cnt_ff <= '0;
         tot_ff <= '0; en_ff <= '0; mx_ff <= '0; mn_ff <= '1;
         ov_ff <= 1'b0; step_ff <= '0; mid_ff <= '0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in;
         p1_ff <= p1_in; p2_ff <= p2_in; cnt_ff <= cnt_in;
         tot_ff <= tot_in; en_ff <= en_in; mx_ff <= mx_in; mn_ff <= mn_in;
         ov_ff <= ov_in; step_ff <= step_in; mid_ff <= mid_in;
      end
      fin_ff <= fin_in;
      adx_ff <= adx_in; ad2_ff <= ad2_in; neg_ff <= neg_in;
      m_ff <= m_in; sq_ff <= sq_in; kap_ff <= kap_in; tx_ff <= tx_in; ty_ff <= ty_in;
      pidx_ff <= pidx_in; acc_ff <= acc_in; ne_ff <= ne_in;
      var_ff <= var_in; mean_ff <= mean_in; sd_ff <= sd_in;
      od_ff <= od_in; ou_ff <= ou_in; ol_ff <= ol_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;
endmodule
